/* sv/soas_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and codes for the second-order actuator step block.
package soas_pkg;

  // Channel bank size and the index width it needs (at most 32 channels fit the 5-bit field).
  localparam int CHANNELS = 24;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths fixed by the item format.
  localparam int CH_W   = 5;
  localparam int POS_W  = 16;
  localparam int VEL_W  = 32;
  localparam int PAR_W  = 16;
  localparam int TS_W   = 19;

  // Time step after reset, in units of 2^-24 s.
  localparam logic [TS_W-1:0] TS_RESET = 19'd16777;

  // 2*pi in Q28.
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;

  // Internal datapath widths.
  localparam int OMEGA_W = 27;  // Q16 rad/s
  localparam int OM2_W   = 38;  // Q16
  localparam int KD_W    = 32;  // Q16
  localparam int ERR_W   = 17;  // Q4.12 difference
  localparam int SPR_W   = 44;  // Q16 spring term
  localparam int DAMP_W  = 49;  // Q16 damping term
  localparam int ACC_W   = 50;  // Q16 acceleration
  localparam int DVH_W   = 46;  // whole part of the velocity change
  localparam int DVL_W   = 19;  // fractional carry of the velocity change
  localparam int VSUM_W  = 48;
  localparam int DP_W    = 24;
  localparam int PSUM_W  = 25;

  // Item operation codes.
  localparam logic OPC_WRITE = 1'b0;
  localparam logic OPC_STEP  = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [CH_W-1:0]         channel;
    logic signed [POS_W-1:0] target;
    logic signed [POS_W-1:0] lower_bound;
    logic signed [POS_W-1:0] upper_bound;
    logic [PAR_W-1:0]        natural_freq;
    logic [PAR_W-1:0]        damping_ratio;
  } in_item_t;

  typedef struct packed {
    logic [PAR_W-1:0]        damping_ratio;
    logic [PAR_W-1:0]        natural_freq;
    logic signed [POS_W-1:0] upper_bound;
    logic signed [POS_W-1:0] lower_bound;
  } chan_par_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_OMEGA,
    ST_OM2,
    ST_KD,
    ST_SPRING,
    ST_DAMP,
    ST_ACC,
    ST_DVH,
    ST_VEL,
    ST_DP,
    ST_POS,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_OMEGA,
    DP_OM2,
    DP_KD,
    DP_SPRING,
    DP_DAMP,
    DP_ACC,
    DP_DVH,
    DP_VEL,
    DP_DP,
    DP_POS
  } dp_op_t;

  typedef struct packed {
    logic   take;
    dp_op_t op;
    logic   load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_step;
    logic out_busy;
  } dp_stat_t;

endpackage

/* sv/soas_if.sv */
`timescale 1ns / 1ps
// Channel interfaces: input items, result items and the time step write port.
interface soas_in_if;
  import soas_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [CH_W-1:0]         channel;
  logic signed [POS_W-1:0] target;
  logic signed [POS_W-1:0] lower_bound;
  logic signed [POS_W-1:0] upper_bound;
  logic [PAR_W-1:0]        natural_freq;
  logic [PAR_W-1:0]        damping_ratio;

  modport source (output valid, op, channel, target, lower_bound, upper_bound,
                  natural_freq, damping_ratio, input ready);
  modport sink (input valid, op, channel, target, lower_bound, upper_bound,
                natural_freq, damping_ratio, output ready);
endinterface

interface soas_out_if;
  import soas_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;
  logic signed [VEL_W-1:0] velocity;
  logic                    status;

  modport source (output valid, position, velocity, status, input ready);
  modport sink (input valid, position, velocity, status, output ready);
endinterface

interface soas_cfg_if;
  import soas_pkg::*;
  logic            valid;
  logic            ready;
  logic [TS_W-1:0] time_step;

  modport source (output valid, time_step, input ready);
  modport sink (input valid, time_step, output ready);
endinterface

/* sv/soas_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer that walks one item through the datapath, at most one multiply per state.
module soas_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  soas_pkg::dp_stat_t   stat,
  output soas_pkg::ctrl_cmd_t  cmd
);
  import soas_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = stat.is_step ? ST_OMEGA : ST_FINISH;
      end
      ST_OMEGA:  state_nxt = ST_OM2;
      ST_OM2:    state_nxt = ST_KD;
      ST_KD:     state_nxt = ST_SPRING;
      ST_SPRING: state_nxt = ST_DAMP;
      ST_DAMP:   state_nxt = ST_ACC;
      ST_ACC:    state_nxt = ST_DVH;
      ST_DVH:    state_nxt = ST_VEL;
      ST_VEL:    state_nxt = ST_DP;
      ST_DP:     state_nxt = ST_POS;
      ST_POS:    state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (!stat.out_busy) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.take     = 1'b0;
    cmd.op       = DP_NOP;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_LOAD:   cmd.op = DP_LOAD;
      ST_OMEGA:  cmd.op = DP_OMEGA;
      ST_OM2:    cmd.op = DP_OM2;
      ST_KD:     cmd.op = DP_KD;
      ST_SPRING: cmd.op = DP_SPRING;
      ST_DAMP:   cmd.op = DP_DAMP;
      ST_ACC:    cmd.op = DP_ACC;
      ST_DVH:    cmd.op = DP_DVH;
      ST_VEL:    cmd.op = DP_VEL;
      ST_DP:     cmd.op = DP_DP;
      ST_POS:    cmd.op = DP_POS;
      ST_FINISH: cmd.load_out = !stat.out_busy;
      default:   cmd.op = DP_NOP;
    endcase
  end

  // An accepted beat is always followed by the state-array read.
  a_take_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> state_r == ST_LOAD)
    else $error("accepted item did not move to LOAD");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !stat.out_busy)
    else $error("result register overwritten while full");

  // A blocked result holds the sequencer in FINISH.
  a_hold_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && stat.out_busy) |=> state_r == ST_FINISH)
    else $error("left FINISH with result register full");

endmodule

/* sv/soas_dpath.sv */
`timescale 1ns / 1ps
// Datapath: channel state arrays, parameter store, step arithmetic and result register.
module soas_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  soas_pkg::in_item_t            in_item,
  input  soas_pkg::ctrl_cmd_t           cmd,
  output soas_pkg::dp_stat_t            stat,
  input  logic                          cfg_we,
  input  logic [soas_pkg::TS_W-1:0]     cfg_time_step,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [soas_pkg::POS_W-1:0] out_position,
  output logic signed [soas_pkg::VEL_W-1:0] out_velocity,
  output logic                          out_status
);
  import soas_pkg::*;

  // Per-channel storage.
  logic signed [POS_W-1:0] pos_mem_r [CHANNELS];
  logic signed [VEL_W-1:0] vel_mem_r [CHANNELS];
  chan_par_t               par_mem_r [CHANNELS];

  // Latched item.
  logic                    op_r;
  logic [CH_IDX_W-1:0]     idx_r;
  logic                    rng_r;
  logic signed [POS_W-1:0] tgt_r;
  chan_par_t               wpar_r;

  logic [TS_W-1:0]         ts_r;

  // Working registers.
  chan_par_t                par_r;
  logic signed [POS_W-1:0]  pos_r;
  logic signed [VEL_W-1:0]  vel_r;
  logic [OMEGA_W-1:0]       omega_r;
  logic signed [ERR_W-1:0]  err_r;
  logic [OM2_W-1:0]         om2_r;
  logic [KD_W-1:0]          kd_r;
  logic signed [SPR_W-1:0]  spring_r;
  logic signed [DAMP_W-1:0] damp_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [DVH_W-1:0]  dvh_r;
  logic signed [DP_W-1:0]   dp_r;
  logic                     sat_r;

  logic                     out_valid_r;
  logic signed [POS_W-1:0]  out_pos_r;
  logic signed [VEL_W-1:0]  out_vel_r;
  logic                     out_stat_r;

  // Combinational step terms.
  logic signed [POS_W-1:0]  tgt_clamp;
  logic [46:0]              om_prod;
  logic [53:0]              om2_prod;
  logic [42:0]              kd_prod;
  logic signed [55:0]       sp_prod;
  logic signed [64:0]       dm_prod;
  logic signed [DVH_W-1:0]  dvh_prod;
  logic [42:0]              dvl_prod;
  logic [DVL_W-1:0]         dvl;
  logic signed [VSUM_W-1:0] vsum;
  logic                     vsum_ovf;
  logic signed [VEL_W-1:0]  vel_sat;
  logic signed [51:0]       dp_prod;
  logic signed [PSUM_W-1:0] psum;
  logic                     psum_ovf;
  logic signed [POS_W-1:0]  pos_sat;

  always_comb begin
    tgt_clamp = tgt_r;
    if (tgt_clamp < par_r.lower_bound) tgt_clamp = par_r.lower_bound;
    if (tgt_clamp > par_r.upper_bound) tgt_clamp = par_r.upper_bound;

    om_prod  = 47'(par_r.natural_freq) * 47'(TWO_PI_Q28);
    om2_prod = 54'(omega_r) * 54'(omega_r);
    kd_prod  = 43'(par_r.damping_ratio) * 43'(omega_r);
    sp_prod  = 56'($signed({1'b0, om2_r})) * 56'(err_r);
    dm_prod  = 65'($signed({1'b0, kd_r})) * 65'(vel_r);

    // Acceleration times step, split at bit 24 of the acceleration.
    dvh_prod = DVH_W'($signed(acc_r[ACC_W-1:24])) * DVH_W'($signed({1'b0, ts_r}));
    dvl_prod = 43'(acc_r[23:0]) * 43'(ts_r);
    dvl      = dvl_prod[42:24];

    vsum     = VSUM_W'(vel_r) + VSUM_W'(dvh_r) + VSUM_W'($signed({1'b0, dvl}));
    vsum_ovf = !(&vsum[VSUM_W-1:VEL_W-1] || ~|vsum[VSUM_W-1:VEL_W-1]);
    if (!vsum_ovf) begin
      vel_sat = vsum[VEL_W-1:0];
    end else if (vsum[VSUM_W-1]) begin
      vel_sat = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      vel_sat = {1'b0, {(VEL_W-1){1'b1}}};
    end

    dp_prod  = 52'(vel_r) * 52'($signed({1'b0, ts_r}));

    psum     = PSUM_W'(pos_r) + PSUM_W'(dp_r);
    psum_ovf = !(&psum[PSUM_W-1:POS_W-1] || ~|psum[PSUM_W-1:POS_W-1]);
    if (!psum_ovf) begin
      pos_sat = psum[POS_W-1:0];
    end else if (psum[PSUM_W-1]) begin
      pos_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      pos_sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= TS_RESET;
    end else if (cfg_we) begin
      ts_r <= cfg_time_step;
    end
  end

  // Item capture at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= in_item.op;
      idx_r  <= in_item.channel[CH_IDX_W-1:0];
      rng_r  <= 32'(in_item.channel) < CHANNELS;
      tgt_r  <= in_item.target;
      wpar_r <= '{damping_ratio: in_item.damping_ratio,
                  natural_freq:  in_item.natural_freq,
                  upper_bound:   in_item.upper_bound,
                  lower_bound:   in_item.lower_bound};
    end
  end

  // Position and velocity arrays start at zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_mem_r[i] <= '0;
        vel_mem_r[i] <= '0;
      end
    end else if (cmd.op == DP_POS) begin
      pos_mem_r[idx_r] <= pos_sat;
      vel_mem_r[idx_r] <= vel_r;
    end
  end

  // Parameter store has no reset; a channel must be written before it is stepped, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD && rng_r && op_r == OPC_WRITE) begin
      par_mem_r[idx_r] <= wpar_r;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        par_r <= par_mem_r[idx_r];
        pos_r <= pos_mem_r[idx_r];
        vel_r <= vel_mem_r[idx_r];
        sat_r <= 1'b0;
      end
      DP_OMEGA: begin
        omega_r <= om_prod[46:20];
        err_r   <= ERR_W'(tgt_clamp) - ERR_W'(pos_r);
      end
      DP_OM2:    om2_r    <= om2_prod[53:16];
      DP_KD:     kd_r     <= kd_prod[42:11];
      DP_SPRING: spring_r <= sp_prod[55:12];
      DP_DAMP:   damp_r   <= dm_prod[64:16];
      DP_ACC:    acc_r    <= ACC_W'(spring_r) - ACC_W'(damp_r);
      DP_DVH:    dvh_r    <= dvh_prod;
      DP_VEL: begin
        vel_r <= vel_sat;
        sat_r <= vsum_ovf;
      end
      DP_DP:     dp_r     <= dp_prod[51:28];
      DP_POS: begin
        pos_r <= pos_sat;
        sat_r <= sat_r | psum_ovf;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Out-of-range channels report zeros; write items report status clear.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pos_r  <= rng_r ? pos_r : '0;
      out_vel_r  <= rng_r ? vel_r : '0;
      out_stat_r <= rng_r && op_r == OPC_STEP && sat_r;
    end
  end

  assign stat = '{is_step:  rng_r && op_r == OPC_STEP,
                  out_busy: out_valid_r && !out_ready};

  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;
  assign out_velocity = out_vel_r;
  assign out_status   = out_stat_r;

  // A loaded result is presented on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

/* sv/second_order_actuator_step_core.sv */
`timescale 1ns / 1ps
// Top level of the second-order actuator step block.
//
//   Channel  Direction  Payload                                     Handshake
//   in_ch    sink       op, channel, target, bounds, freq, damping  valid/ready
//   out_ch   source     position, velocity, status                  valid/ready
//   cfg_ch   sink       time_step                                   valid/ready
//
// A step beat passes from acceptance through one state-array read, ten datapath
// states each built around a single multiply or add/saturate, and a final state
// that loads the result register. Parameter-write beats and beats for channels beyond
// the bank skip the datapath states and go from the read straight to that load.
// Reset (rst_n low, synchronous) zeroes all positions and velocities and sets
// the time step to 16777; channel parameters are unknown until written.
// The result register lets a new beat be accepted while a result waits; a stalled
// result holds the sequencer in its last state until out_ch drains it.
// Neither sink is ready during reset. Out of reset the time step port is always
// ready; it is to be written only while the block is idle, which the block does not enforce.
//
// Each step forms omega = 2*pi*f, the spring and damping terms, then advances
// velocity and afterwards position from the new velocity (semi-implicit Euler).
// Velocity saturates to 32 bits and position to 16 bits; either sets status.
module second_order_actuator_step_core (
  input  logic        clk,
  input  logic        rst_n,
  soas_in_if.sink     in_ch,
  soas_out_if.source  out_ch,
  soas_cfg_if.sink    cfg_ch
);
  import soas_pkg::*;

  in_item_t  in_item;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  assign in_item = '{op:            in_ch.op,
                     channel:       in_ch.channel,
                     target:        in_ch.target,
                     lower_bound:   in_ch.lower_bound,
                     upper_bound:   in_ch.upper_bound,
                     natural_freq:  in_ch.natural_freq,
                     damping_ratio: in_ch.damping_ratio};

  assign in_ch.ready  = in_ready && rst_n;
  assign cfg_ch.ready = rst_n;

  // Sequencer: one state per arithmetic step.
  soas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic, channel storage and the result register.
  soas_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_item       (in_item),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_ch.valid && cfg_ch.ready),
    .cfg_time_step (cfg_ch.time_step),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_position  (out_ch.position),
    .out_velocity  (out_ch.velocity),
    .out_status    (out_ch.status)
  );

endmodule

/* bench/tb_second_order_actuator_step_core.sv */
`timescale 1ns / 1ps
// Self-checking bench for the second-order actuator step block, with a built-in predictor.
module tb_second_order_actuator_step_core;
  import soas_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 6;
  // Random beats per phase (out-of-range channel beats come on top of these).
  localparam int PHASE_ITEMS [PHASES] = '{300, 350, 200, 200, 250, 450};
  localparam logic [TS_W-1:0] TS_MAX_LEGAL = 19'd335544;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [VEL_W-1:0] velocity;
    logic                    status;
  } actuator_state_t;

  logic clk;
  logic rst_n;

  soas_in_if  in_if ();
  soas_out_if out_if ();
  soas_cfg_if cfg_if ();

  second_order_actuator_step_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #5 clk = ~clk;

  // Commands waiting for the driver, and the readbacks the block still owes us.
  in_item_t        command_queue [$];
  actuator_state_t states_due [$];

  // Predictor copy of the block's registers and channel bank.
  logic [TS_W-1:0] step_ticks;
  longint          chan_lo [CHANNELS];
  longint          chan_hi [CHANNELS];
  longint          chan_freq [CHANNELS];
  longint          chan_damp [CHANNELS];
  longint          chan_pos [CHANNELS];
  longint          chan_vel [CHANNELS];

  // Stimulus bookkeeping: a channel is stepped only once its parameters exist.
  bit              param_written [CHANNELS];
  int              last_channel;

  int send_idle_pct;
  int recv_stall_pct;
  logic in_taken;
  int items_queued;
  int results_checked;
  int error_count;
  int cycle_count;
  int write_beats, step_beats, stray_beats, saturated_steps, ts_settings;

  // Advance the predicted channel bank by one command and return the readback.
  function automatic actuator_state_t advance_actuator(in_item_t cmd);
    actuator_state_t r;
    int     ch;
    longint tgt, pos, vel, dt, omega, om2, spring, kd, damp, acc, acc_hi, dv, dp;
    r  = '0;
    ch = cmd.channel;
    if (ch >= CHANNELS) begin
      stray_beats++;
      return r;
    end
    if (cmd.op == OPC_WRITE) begin
      write_beats++;
      chan_lo[ch]   = longint'($signed(cmd.lower_bound));
      chan_hi[ch]   = longint'($signed(cmd.upper_bound));
      chan_freq[ch] = longint'(cmd.natural_freq);
      chan_damp[ch] = longint'(cmd.damping_ratio);
    end else begin
      step_beats++;
      // The lower bound is applied first, so an inverted pair ends on the upper bound.
      tgt = longint'($signed(cmd.target));
      if (tgt < chan_lo[ch]) tgt = chan_lo[ch];
      if (tgt > chan_hi[ch]) tgt = chan_hi[ch];
      pos    = chan_pos[ch];
      vel    = chan_vel[ch];
      dt     = longint'(step_ticks);
      omega  = (chan_freq[ch] * longint'(TWO_PI_Q28)) >>> 20;
      om2    = (omega * omega) >>> 16;
      spring = (om2 * (tgt - pos)) >>> 12;
      kd     = (2 * chan_damp[ch] * omega) >>> 12;
      damp   = (kd * vel) >>> 16;
      acc    = spring - damp;
      // acc*dt >> 24, taken in a whole part and a fractional carry.
      acc_hi = acc >>> 24;
      dv     = acc_hi * dt + (((acc - (acc_hi <<< 24)) * dt) >>> 24);
      vel    = vel + dv;
      if (vel > 64'sd2147483647) begin
        vel = 64'sd2147483647;
        r.status = 1'b1;
      end else if (vel < -64'sd2147483648) begin
        vel = -64'sd2147483648;
        r.status = 1'b1;
      end
      // Position moves with the velocity that was just updated.
      dp  = (vel * dt) >>> 28;
      pos = pos + dp;
      if (pos > 64'sd32767) begin
        pos = 64'sd32767;
        r.status = 1'b1;
      end else if (pos < -64'sd32768) begin
        pos = -64'sd32768;
        r.status = 1'b1;
      end
      chan_pos[ch] = pos;
      chan_vel[ch] = vel;
      if (r.status) saturated_steps++;
    end
    r.position = POS_W'(chan_pos[ch]);
    r.velocity = VEL_W'(chan_vel[ch]);
    return r;
  endfunction

  function automatic in_item_t make_item(logic op, int ch, int tgt, int lo, int hi,
                                         int freq, int damp);
    in_item_t cmd;
    cmd.op            = op;
    cmd.channel       = CH_W'(ch);
    cmd.target        = POS_W'(tgt);
    cmd.lower_bound   = POS_W'(lo);
    cmd.upper_bound   = POS_W'(hi);
    cmd.natural_freq  = PAR_W'(freq);
    cmd.damping_ratio = PAR_W'(damp);
    return cmd;
  endfunction

  // Mostly well-formed traffic: parameter writes followed by runs of steps on a
  // channel, with some full-range parameters and a little out-of-range noise.
  function automatic in_item_t random_command();
    in_item_t cmd;
    int pick, ch;
    logic signed [POS_W-1:0] a, b;
    cmd  = make_item(OPC_STEP, 0, $urandom_range(65535), $urandom_range(65535),
                     $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 7) begin
      cmd.op      = 1'($urandom_range(1));
      cmd.channel = CH_W'($urandom_range(31, CHANNELS));
    end else if (pick < 20) begin
      cmd.op      = OPC_WRITE;
      cmd.channel = CH_W'($urandom_range(CHANNELS - 1));
      if ($urandom_range(99) < 70) begin
        // Plausible actuator: ordered bounds, up to 60 Hz, damping up to 3.
        a = POS_W'($urandom_range(65535));
        b = POS_W'($urandom_range(65535));
        cmd.lower_bound   = (a < b) ? a : b;
        cmd.upper_bound   = (a < b) ? b : a;
        cmd.natural_freq  = PAR_W'($urandom_range(15360));
        cmd.damping_ratio = PAR_W'($urandom_range(12288));
      end
    end else begin
      ch = (($urandom_range(99) < 55)) ? last_channel : $urandom_range(CHANNELS - 1);
      if (!param_written[ch]) ch = last_channel;
      cmd.channel = CH_W'(ch);
      if ($urandom_range(99) < 12) cmd.target = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    end
    return cmd;
  endfunction

  task automatic queue_command(in_item_t cmd);
    if (cmd.op == OPC_WRITE && cmd.channel < CHANNELS) param_written[cmd.channel] = 1'b1;
    if (cmd.op == OPC_STEP && cmd.channel < CHANNELS) last_channel = cmd.channel;
    command_queue.insert(command_queue.size(), cmd);
    items_queued++;
  endtask

  // Returns once every queued command has produced its readback and the block has settled.
  task automatic wait_block_idle();
    while (results_checked != items_queued) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_time_step(logic [TS_W-1:0] value);
    @(negedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.time_step <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    ts_settings++;
  endtask

  // Input driver: a new beat may be offered whenever the previous one was taken or none is up.
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || in_taken)) begin
      if (command_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item_t cmd;
        cmd = command_queue.pop_front();
        in_if.valid         <= 1'b1;
        in_if.op            <= cmd.op;
        in_if.channel       <= cmd.channel;
        in_if.target        <= cmd.target;
        in_if.lower_bound   <= cmd.lower_bound;
        in_if.upper_bound   <= cmd.upper_bound;
        in_if.natural_freq  <= cmd.natural_freq;
        in_if.damping_ratio <= cmd.damping_ratio;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: checks readbacks first, then predicts for a beat taken on the same edge.
  always @(posedge clk) begin
    actuator_state_t due;
    in_item_t        cmd;
    in_taken <= rst_n && in_if.valid && in_if.ready;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) step_ticks = cfg_if.time_step;
      if (out_if.valid && out_if.ready) begin
        if (states_due.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result position %0d velocity %0d status %0b", $time,
                   out_if.position, out_if.velocity, out_if.status);
        end else begin
          due = states_due.pop_front();
          results_checked++;
          if (out_if.position !== due.position) begin
            error_count++;
            $display("%0t: position expected %0d actual %0d", $time, due.position,
                     out_if.position);
          end
          if (out_if.velocity !== due.velocity) begin
            error_count++;
            $display("%0t: velocity expected %0d actual %0d", $time, due.velocity,
                     out_if.velocity);
          end
          if (out_if.status !== due.status) begin
            error_count++;
            $display("%0t: status expected %0b actual %0b", $time, due.status,
                     out_if.status);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        cmd.op            = in_if.op;
        cmd.channel       = in_if.channel;
        cmd.target        = in_if.target;
        cmd.lower_bound   = in_if.lower_bound;
        cmd.upper_bound   = in_if.upper_bound;
        cmd.natural_freq  = in_if.natural_freq;
        cmd.damping_ratio = in_if.damping_ratio;
        states_due.insert(states_due.size(), advance_actuator(cmd));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out with %0d readbacks outstanding", states_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int n;
    in_item_t cmd;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.op            = OPC_WRITE;
    in_if.channel       = '0;
    in_if.target        = '0;
    in_if.lower_bound   = '0;
    in_if.upper_bound   = '0;
    in_if.natural_freq  = '0;
    in_if.damping_ratio = '0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.time_step    = '0;
    in_taken            = 1'b0;
    step_ticks          = TS_RESET;
    for (int i = 0; i < CHANNELS; i++) begin
      chan_lo[i] = 0; chan_hi[i] = 0; chan_freq[i] = 0; chan_damp[i] = 0;
      chan_pos[i] = 0; chan_vel[i] = 0; param_written[i] = 1'b0;
    end
    last_channel = 0;
    items_queued = 0; results_checked = 0; error_count = 0; cycle_count = 0;
    write_beats = 0; step_beats = 0; stray_beats = 0; saturated_steps = 0; ts_settings = 0;
    send_idle_pct  = 26;
    recv_stall_pct = 82;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening at the reset time step.
    // Full-range bounds, 10 Hz, damping 0.7: drive to both ends and back.
    queue_command(make_item(OPC_WRITE, 0, 0, -32768, 32767, 2560, 2867));
    queue_command(make_item(OPC_STEP, 0, 32767, 0, 0, 0, 0));
    queue_command(make_item(OPC_STEP, 0, -32768, 0, 0, 0, 0));
    queue_command(make_item(OPC_STEP, 0, 0, 0, 0, 0, 0));
    // Inverted bounds on the last channel with the largest frequency and damping.
    queue_command(make_item(OPC_WRITE, CHANNELS - 1, 0, 8192, -8192, 65535, 65535));
    queue_command(make_item(OPC_STEP, CHANNELS - 1, -32768, 0, 0, 0, 0));
    queue_command(make_item(OPC_STEP, CHANNELS - 1, 32767, 0, 0, 0, 0));
    queue_command(make_item(OPC_STEP, CHANNELS - 1, 32767, 0, 0, 0, 0));
    // Zero frequency and damping: a step cannot move the channel.
    queue_command(make_item(OPC_WRITE, 1, 0, -32768, 32767, 0, 0));
    queue_command(make_item(OPC_STEP, 1, 20000, 0, 0, 0, 0));
    // Channels beyond the bank, both operations, the last two with all field bits set.
    queue_command(make_item(OPC_STEP, CHANNELS, 1234, 0, 0, 0, 0));
    queue_command(make_item(OPC_STEP, 31, -1, -1, -1, 65535, 65535));
    queue_command(make_item(OPC_WRITE, 31, -1, -1, -1, 65535, 65535));
    // Narrow window, undamped 50 Hz: the target is clipped to the upper bound.
    queue_command(make_item(OPC_WRITE, 5, 0, -4096, 4096, 12800, 0));
    for (int i = 0; i < 4; i++) queue_command(make_item(OPC_STEP, 5, 32767, 0, 0, 0, 0));
    // Heavy damping at 100 Hz.
    queue_command(make_item(OPC_WRITE, 2, 0, -16384, 16384, 25600, 65535));
    queue_command(make_item(OPC_STEP, 2, -32768, 0, 0, 0, 0));
    queue_command(make_item(OPC_STEP, 2, -32768, 0, 0, 0, 0));
    // A parameter rewrite reads back the current state unchanged.
    queue_command(make_item(OPC_WRITE, 0, -1, 0, 0, 65535, 0));
    queue_command(make_item(OPC_WRITE, 0, 0, -32768, 32767, 2560, 2867));
    queue_command(make_item(OPC_STEP, 0, 16384, 0, 0, 0, 0));

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        wait_block_idle();
        if (phase == 2) begin
          send_idle_pct  = 82;
          recv_stall_pct = 26;
        end else if (phase == 4) begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        // Largest legal step, the smallest, zero, the register maximum, then a random one.
        case (phase)
          1: write_time_step(TS_MAX_LEGAL);
          2: write_time_step(19'd1);
          3: write_time_step(19'd0);
          4: write_time_step(19'h7FFFF);
          default: write_time_step(TS_W'($urandom_range(int'(TS_MAX_LEGAL), 1)));
        endcase
      end
      n = 0;
      while (n < PHASE_ITEMS[phase]) begin
        cmd = random_command();
        if (cmd.channel < CHANNELS) n++;
        queue_command(cmd);
      end
    end

    wait_block_idle();
    if (states_due.size() != 0) begin
      error_count++;
      $display("%0t: %0d readbacks never arrived", $time, states_due.size());
    end
    $display("Covered %0d parameter writes, %0d steps (%0d saturating), %0d stray beats",
             write_beats, step_beats, saturated_steps, stray_beats);
    $display("across %0d time step settings; %0d mismatches", ts_settings + 1, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
